>>> sv/sparse_vector_euclidean_distance_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse vector Euclidean distance unit
// Concurrent check wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef SPARSE_VECTOR_EUCLIDEAN_DISTANCE_UNIT_MACROS_SVH
`define SPARSE_VECTOR_EUCLIDEAN_DISTANCE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SVEDU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svedu same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SVEDU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svedu next-cycle check failed");

`else

`define SVEDU_ASSERT_IMP(label, ante, cons)
`define SVEDU_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> sv/svedu_pkg.sv
// ----------------------------------------------------------------------------
// Sparse vector Euclidean distance package
// Sizes, op codes and the command/status bundles shared by the unit.
// ----------------------------------------------------------------------------
package svedu_pkg;

  // Capacity and field widths.
  localparam int MAX_NONZERO = 256;
  localparam int INDEX_BITS  = 20;
  localparam int IN_INDEX_W  = 20;
  localparam int VALUE_W     = 16;
  localparam int OP_W        = 2;
  localparam int SUM_W       = 42;
  localparam int ROOT_W      = SUM_W / 2;

  // Derived widths.
  localparam int CNT_W    = $clog2(MAX_NONZERO + 1);
  localparam int ADDR_W   = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;
  localparam int OPND_W   = VALUE_W + 1;
  localparam int TERM_W   = 2 * VALUE_W + 1;
  localparam int REM_W    = ROOT_W + 3;
  localparam int SQ_CNT_W = $clog2(ROOT_W + 1);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic cmp;
    logic mul;
    logic acc;
    logic sq_init;
    logic sq_step;
    logic finish;
  } svedu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic merge_done;
    logic sq_last;
  } svedu_sts_t;

endpackage

>>> sv/svedu_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse vector Euclidean distance controller
// Sequences loads, the merge walk, the square root and the result handoff.
// ----------------------------------------------------------------------------
module svedu_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [svedu_pkg::OP_W-1:0] in_op,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  svedu_pkg::svedu_sts_t     sts,
  output svedu_pkg::svedu_cmd_t     cmd
);
  import svedu_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_SQI  = 3'd5;
  localparam logic [2:0] ST_SQS  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // A compute waits until the previous result word has been taken.
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || (in_op != OP_COMPUTE));
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Command decode.
  always_comb begin
    cmd         = '0;
    cmd.load_a  = accept && (in_op == OP_LOAD_A);
    cmd.load_b  = accept && (in_op == OP_LOAD_B);
    cmd.start   = accept && (in_op == OP_COMPUTE);
    cmd.cmp     = (state_r == ST_CMP);
    cmd.mul     = (state_r == ST_MUL);
    cmd.acc     = (state_r == ST_ACC);
    cmd.sq_init = (state_r == ST_SQI);
    cmd.sq_step = (state_r == ST_SQS);
    cmd.finish  = (state_r == ST_FIN);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = sts.merge_done ? ST_SQI : ST_RD;
        end
      end
      ST_RD:  state_nxt = ST_CMP;
      ST_CMP: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = sts.merge_done ? ST_SQI : ST_RD;
      ST_SQI: state_nxt = ST_SQS;
      ST_SQS: state_nxt = sts.sq_last ? ST_FIN : ST_SQS;
      ST_FIN: state_nxt = ST_IDLE;
    endcase
  end

  // Result word valid flag.
  always_comb begin
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/svedu_dp.sv
// ----------------------------------------------------------------------------
// Sparse vector Euclidean distance datapath
// Entry stores, merge pointers, squarer, saturating sum and square root unit.
// ----------------------------------------------------------------------------
module svedu_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  svedu_pkg::svedu_cmd_t              cmd,
  output svedu_pkg::svedu_sts_t              sts,
  input  logic [svedu_pkg::IN_INDEX_W-1:0]   in_entry_index,
  input  logic signed [svedu_pkg::VALUE_W-1:0] in_entry_value,
  output logic [svedu_pkg::SUM_W-1:0]        out_distance_squared,
  output logic [svedu_pkg::ROOT_W-1:0]       out_distance,
  output logic                               out_load_error
);
  import svedu_pkg::*;

  // Entry stores.
  logic [INDEX_BITS-1:0] a_idx_mem [MAX_NONZERO];
  logic [VALUE_W-1:0]    a_val_mem [MAX_NONZERO];
  logic [INDEX_BITS-1:0] b_idx_mem [MAX_NONZERO];
  logic [VALUE_W-1:0]    b_val_mem [MAX_NONZERO];

  logic [INDEX_BITS-1:0] a_idx_q, b_idx_q;
  logic [VALUE_W-1:0]    a_val_q, b_val_q;

  // Fill state and merge pointers.
  logic [CNT_W-1:0]      a_cnt_r, b_cnt_r, i_r, j_r;
  logic [INDEX_BITS-1:0] a_last_r, b_last_r;
  logic                  err_r;

  // Arithmetic registers.
  logic signed [OPND_W-1:0] opnd_r, opnd_nxt;
  logic [TERM_W-1:0]        prod_r;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [SUM_W-1:0]         sq_n_r;
  logic [REM_W-1:0]         sq_rem_r;
  logic [ROOT_W-1:0]        sq_root_r;
  logic [SQ_CNT_W-1:0]      sq_cnt_r;

  // Result word registers.
  logic [SUM_W-1:0]  dsq_r;
  logic [ROOT_W-1:0] dist_r;
  logic              lerr_r;

  logic [INDEX_BITS-1:0]    idx_in;
  logic                     a_drop, b_drop, a_wr, b_wr;
  logic                     a_avail, b_avail, take_a, take_b;
  logic signed [OPND_W-1:0] a_sv, b_sv;
  logic signed [2*OPND_W-1:0] sq_full;
  logic [SUM_W:0]           sum_ext;
  logic [REM_W-1:0]         rem_sh, trial;
  logic                     rem_ge;

  // Load checks: a full vector or a non-ascending index drops the entry.
  assign idx_in = in_entry_index[INDEX_BITS-1:0];
  assign a_drop = (a_cnt_r == CNT_W'(MAX_NONZERO)) ||
                  ((a_cnt_r != '0) && (idx_in <= a_last_r));
  assign b_drop = (b_cnt_r == CNT_W'(MAX_NONZERO)) ||
                  ((b_cnt_r != '0) && (idx_in <= b_last_r));
  assign a_wr   = cmd.load_a && !a_drop;
  assign b_wr   = cmd.load_b && !b_drop;

  // Store writes at the fill count and registered reads at the merge pointers.
  always_ff @(posedge clk) begin
    if (a_wr) begin
      a_idx_mem[a_cnt_r[ADDR_W-1:0]] <= idx_in;
      a_val_mem[a_cnt_r[ADDR_W-1:0]] <= in_entry_value;
    end
    if (b_wr) begin
      b_idx_mem[b_cnt_r[ADDR_W-1:0]] <= idx_in;
      b_val_mem[b_cnt_r[ADDR_W-1:0]] <= in_entry_value;
    end
    a_idx_q <= a_idx_mem[i_r[ADDR_W-1:0]];
    a_val_q <= a_val_mem[i_r[ADDR_W-1:0]];
    b_idx_q <= b_idx_mem[j_r[ADDR_W-1:0]];
    b_val_q <= b_val_mem[j_r[ADDR_W-1:0]];
  end

  // Merge decision: the smaller index goes alone, equal indexes pair up.
  assign a_avail = (i_r < a_cnt_r);
  assign b_avail = (j_r < b_cnt_r);
  assign take_a  = !b_avail || (a_avail && (a_idx_q < b_idx_q));
  assign take_b  = !take_a && (!a_avail || (b_idx_q < a_idx_q));
  assign a_sv    = OPND_W'(signed'(a_val_q));
  assign b_sv    = OPND_W'(signed'(b_val_q));

  always_comb begin
    priority if (take_a) begin
      opnd_nxt = a_sv;
    end else if (take_b) begin
      opnd_nxt = b_sv;
    end else begin
      opnd_nxt = a_sv - b_sv;
    end
  end

  assign sts.merge_done = !a_avail && !b_avail;

  // Squarer and saturating accumulator.
  assign sq_full = opnd_r * opnd_r;
  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(prod_r);
  assign sum_nxt = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  // Square root: one result bit per step, two sum bits shifted in.
  assign rem_sh      = {sq_rem_r[REM_W-3:0], sq_n_r[SUM_W-1 -: 2]};
  assign trial       = REM_W'({sq_root_r, 2'b01});
  assign rem_ge      = (rem_sh >= trial);
  assign sts.sq_last = (sq_cnt_r == SQ_CNT_W'(1));

  // Control state: counts, pointers and the sticky flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      err_r   <= 1'b0;
    end else begin
      if (a_wr) begin
        a_cnt_r <= a_cnt_r + CNT_W'(1);
      end
      if (b_wr) begin
        b_cnt_r <= b_cnt_r + CNT_W'(1);
      end
      if ((cmd.load_a && a_drop) || (cmd.load_b && b_drop)) begin
        err_r <= 1'b1;
      end
      if (cmd.cmp) begin
        if (!take_b) begin
          i_r <= i_r + CNT_W'(1);
        end
        if (!take_a) begin
          j_r <= j_r + CNT_W'(1);
        end
      end
      if (cmd.finish) begin
        a_cnt_r <= '0;
        b_cnt_r <= '0;
        i_r     <= '0;
        j_r     <= '0;
        err_r   <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (a_wr) begin
      a_last_r <= idx_in;
    end
    if (b_wr) begin
      b_last_r <= idx_in;
    end
    if (cmd.start) begin
      sum_r <= '0;
    end
    if (cmd.cmp) begin
      opnd_r <= opnd_nxt;
    end
    if (cmd.mul) begin
      prod_r <= sq_full[TERM_W-1:0];
    end
    if (cmd.acc) begin
      sum_r <= sum_nxt;
    end
    if (cmd.sq_init) begin
      sq_n_r    <= sum_r;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= SQ_CNT_W'(ROOT_W);
    end
    if (cmd.sq_step) begin
      sq_n_r    <= sq_n_r << 2;
      sq_rem_r  <= rem_ge ? (rem_sh - trial) : rem_sh;
      sq_root_r <= {sq_root_r[ROOT_W-2:0], rem_ge};
      sq_cnt_r  <= sq_cnt_r - SQ_CNT_W'(1);
    end
    if (cmd.finish) begin
      dsq_r  <= sum_r;
      dist_r <= sq_root_r;
      lerr_r <= err_r;
    end
  end

  assign out_distance_squared = dsq_r;
  assign out_distance         = dist_r;
  assign out_load_error       = lerr_r;

endmodule

>>> sv/sparse_vector_euclidean_distance_unit.sv
// Sequencing: a compute word runs N merge steps, N being at most a_count + b_count,
// each through four states (store read, compare, square, accumulate); the square root
// then takes a setup state, one state per root bit (21 root bits) and a handoff state.
// Loads go one per cycle while the sequencer is idle, also while a result waits.
// Reset (rst_n, synchronous): clears both fill counts, the merge pointers, the error flag,
// the sequencer and the result valid flag; the entry stores are not cleared.
// ----------------------------------------------------------------------------
// Sparse vector Euclidean distance unit
// Loads two sparse vectors, merges them by index and returns the squared
// distance, its integer square root and the sticky load error flag.
// ----------------------------------------------------------------------------
`include "sparse_vector_euclidean_distance_unit_macros.svh"

module sparse_vector_euclidean_distance_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [svedu_pkg::OP_W-1:0]           in_op,
  input  logic [svedu_pkg::IN_INDEX_W-1:0]     in_entry_index,
  input  logic signed [svedu_pkg::VALUE_W-1:0] in_entry_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [svedu_pkg::SUM_W-1:0]          out_distance_squared,
  output logic [svedu_pkg::ROOT_W-1:0]         out_distance,
  output logic                                 out_load_error
);
  import svedu_pkg::*;

  svedu_cmd_t cmd;
  svedu_sts_t sts;

  // Sequencer.
  svedu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Stores and arithmetic.
  svedu_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_entry_index       (in_entry_index),
    .in_entry_value       (in_entry_value),
    .out_distance_squared (out_distance_squared),
    .out_distance         (out_distance),
    .out_load_error       (out_load_error)
  );

  // Bracketing of the root for the checks below.
  logic [SUM_W:0] root_sq;
  logic [SUM_W:0] root_next_sq;

  assign root_sq      = (SUM_W + 1)'(out_distance) * (SUM_W + 1)'(out_distance);
  assign root_next_sq = ((SUM_W + 1)'(out_distance) + (SUM_W + 1)'(1)) *
                        ((SUM_W + 1)'(out_distance) + (SUM_W + 1)'(1));

  // The root is the floor square root of the sum.
  `SVEDU_ASSERT_IMP(a_root_low, out_valid, root_sq <= {1'b0, out_distance_squared})
  `SVEDU_ASSERT_IMP(a_root_high, out_valid, root_next_sq > {1'b0, out_distance_squared})
  // A new compute is held off while a result word is pending.
  `SVEDU_ASSERT_IMP(a_compute_gate, out_valid && (in_op == OP_COMPUTE), !in_ready)
  // After a compute is taken the unit is not ready in the next cycle.
  `SVEDU_ASSERT_NXT(a_compute_busy, in_valid && in_ready && (in_op == OP_COMPUTE), !in_ready)

endmodule

>>> verif/tb_sparse_vector_euclidean_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sparse vector Euclidean distance unit
// Loads sparse vectors A and B as ascending (index, value) words and issues
// compute words. Every accepted word is run through a behavioral model of
// the index merge, and each returned distance is compared field by field.
// A short opening table covers extremes, dropped loads and the unused op.
// Random vector pairs and broken load runs follow, with random idling on
// both sides and one long result stall.
// ----------------------------------------------------------------------------
module tb_sparse_vector_euclidean_distance_unit;
  import svedu_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET  = 1950;
  localparam int HOLD_CYCLES  = 600;
  localparam int TAIL_CYCLES  = 4 * 2 * MAX_NONZERO + 64;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int IDLE_PCT     = 37;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [IN_INDEX_W-1:0]     idx;
    logic signed [VALUE_W-1:0] val;
  } word_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sq;
    logic [ROOT_W-1:0] root;
    logic              err;
  } dist_t;

  // One opening row: the word, and its result where it is typed in by hand.
  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [IN_INDEX_W-1:0]     idx;
    logic signed [VALUE_W-1:0] val;
    bit                        typed;
    logic [SUM_W-1:0]          sq;
    logic [ROOT_W-1:0]         root;
    logic                      err;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           in_op = '0;
  logic [IN_INDEX_W-1:0]     in_entry_index = '0;
  logic signed [VALUE_W-1:0] in_entry_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [SUM_W-1:0]          out_distance_squared;
  logic [ROOT_W-1:0]         out_distance;
  logic                      out_load_error;

  // Model state: side 0 is vector A, side 1 is vector B.
  logic [IN_INDEX_W-1:0]     held_idx [2][MAX_NONZERO];
  logic signed [VALUE_W-1:0] held_val [2][MAX_NONZERO];
  int unsigned               held_cnt [2] = '{0, 0};
  bit                        load_dropped = 1'b0;

  dist_t       distances_due[$];
  dist_t       want;
  int unsigned fail_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_cnt = 0;
  bit          quiet_tx = 1'b0;

  dir_row_t opening_rows [24] = '{
    '{OP_COMPUTE, 20'h00000, 16'sh0000, 1'b1, 42'd0,          21'd0,     1'b0},
    '{OP_UNUSED,  20'hFFFFF, 16'sh7FFF, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_LOAD_A,  20'h00000, 16'sh8000, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_COMPUTE, 20'h00000, 16'sh0000, 1'b1, 42'd1073741824, 21'd32768, 1'b0},
    '{OP_LOAD_B,  20'hFFFFF, 16'sh7FFF, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_COMPUTE, 20'hFFFFF, 16'shFFFF, 1'b1, 42'd1073676289, 21'd32767, 1'b0},
    '{OP_LOAD_A,  20'h00005, 16'sh7FFF, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_LOAD_B,  20'h00005, 16'sh8000, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_COMPUTE, 20'h00000, 16'sh0000, 1'b1, 42'd4294836225, 21'd65535, 1'b0},
    '{OP_LOAD_A,  20'h0000A, 16'sh0064, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_LOAD_A,  20'h0000A, 16'sh00C8, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_LOAD_A,  20'h00003, 16'sh0007, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_COMPUTE, 20'h00000, 16'sh0000, 1'b1, 42'd10000,      21'd100,   1'b1},
    '{OP_COMPUTE, 20'h00000, 16'sh0000, 1'b1, 42'd0,          21'd0,     1'b0},
    '{OP_LOAD_A,  20'h00001, 16'sh0000, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_LOAD_B,  20'h00001, 16'sh0000, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_LOAD_B,  20'h00002, 16'sh0100, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_UNUSED,  20'h00000, 16'sh0000, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_COMPUTE, 20'h00000, 16'sh0000, 1'b1, 42'd65536,      21'd256,   1'b0},
    '{OP_LOAD_A,  20'hAAAAA, 16'sh5555, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_LOAD_A,  20'hFFFFF, 16'shAAAA, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_LOAD_B,  20'h55555, 16'sh1234, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_LOAD_B,  20'hAAAAA, 16'shD555, 1'b0, 42'd0,          21'd0,     1'b0},
    '{OP_COMPUTE, 20'h12345, 16'sh4321, 1'b0, 42'd0,          21'd0,     1'b0}
  };

  sparse_vector_euclidean_distance_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_entry_index       (in_entry_index),
    .in_entry_value       (in_entry_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_distance_squared (out_distance_squared),
    .out_distance         (out_distance),
    .out_load_error       (out_load_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Steps the model by one accepted word; returns 1 when a compute gives a distance.
  function automatic bit merge_distance(input word_t w, output dist_t r);
    int unsigned i, j;
    bit side;
    longint signed d;
    longint unsigned acc, root, trial;
    r = '0;
    if (w.op == OP_LOAD_A || w.op == OP_LOAD_B) begin
      side = (w.op == OP_LOAD_B);
      // Full vectors and non-ascending indexes drop the entry.
      if (held_cnt[side] >= MAX_NONZERO ||
          (held_cnt[side] != 0 && w.idx <= held_idx[side][held_cnt[side] - 1])) begin
        load_dropped = 1'b1;
      end else begin
        held_idx[side][held_cnt[side]] = w.idx;
        held_val[side][held_cnt[side]] = w.val;
        held_cnt[side]++;
      end
      return 1'b0;
    end
    if (w.op != OP_COMPUTE) return 1'b0;

    // Merge both vectors by index and sum the squared terms.
    i = 0;
    j = 0;
    acc = 0;
    while (i < held_cnt[0] || j < held_cnt[1]) begin
      if (j >= held_cnt[1] || (i < held_cnt[0] && held_idx[0][i] < held_idx[1][j])) begin
        d = longint'(held_val[0][i]);
        i++;
      end else if (i >= held_cnt[0] || held_idx[1][j] < held_idx[0][i]) begin
        d = longint'(held_val[1][j]);
        j++;
      end else begin
        d = longint'(held_val[0][i]) - longint'(held_val[1][j]);
        i++;
        j++;
      end
      acc += longint'(d * d);
      if (acc > (64'd1 << SUM_W) - 1) acc = (64'd1 << SUM_W) - 1;
    end

    // Floor square root, one bit at a time from the top.
    root = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= acc) root = trial;
    end

    r.sq = acc[SUM_W-1:0];
    r.root = root[ROOT_W-1:0];
    r.err = load_dropped;
    held_cnt[0] = 0;
    held_cnt[1] = 0;
    load_dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Offers one word from a falling edge until it is taken, then predicts it.
  // A typed result, where given, stands in for the predicted one.
  task automatic send_word(input word_t w, input bit typed, input dist_t typed_r);
    dist_t r;
    while (!quiet_tx && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= w.op;
    in_entry_index <= w.idx;
    in_entry_value <= w.val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (merge_distance(w, r)) begin
      if (typed) r = typed_r;
      distances_due = {distances_due, r};
    end
    if (w.op != OP_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Sends two well-formed vectors, interleaved at random, then a compute word.
  // Both start from one base index so that shared indexes are common.
  task automatic send_vector_pair(input int n_a, input int n_b, input int step_max);
    word_t w;
    dist_t none;
    int unsigned next_idx [2];
    int left [2];
    bit side;
    none = '0;
    next_idx[0] = $urandom_range(0, (1 << IN_INDEX_W) - 1 - step_max * (MAX_NONZERO + 2));
    next_idx[1] = next_idx[0];
    left[0] = n_a;
    left[1] = n_b;
    while (left[0] + left[1] > 0) begin
      if (left[0] == 0) side = 1'b1;
      else if (left[1] == 0) side = 1'b0;
      else side = 1'($urandom_range(1));
      next_idx[side] += $urandom_range(1, step_max);
      w.op = side ? OP_LOAD_B : OP_LOAD_A;
      w.idx = IN_INDEX_W'(next_idx[side]);
      w.val = pick_value();
      send_word(w, 1'b0, none);
      left[side]--;
    end
    w.op = OP_COMPUTE;
    w.idx = IN_INDEX_W'($urandom);
    w.val = VALUE_W'($urandom);
    send_word(w, 1'b0, none);
  endtask

  // Stimulus: reset, the opening table, then random sequences.
  initial begin : stimulus
    word_t w;
    dist_t typed_r;
    int seq_no, n_a, n_b, n_noise;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening_rows[k]) begin
      w.op = opening_rows[k].op;
      w.idx = opening_rows[k].idx;
      w.val = opening_rows[k].val;
      typed_r.sq = opening_rows[k].sq;
      typed_r.root = opening_rows[k].root;
      typed_r.err = opening_rows[k].err;
      send_word(w, opening_rows[k].typed, typed_r);
    end

    seq_no = 0;
    typed_r = '0;
    while (items_sent < ITEM_TARGET) begin
      seq_no++;
      quiet_tx = (seq_no >= 60 && seq_no < 80);
      if (seq_no == 40) begin
        // Both vectors filled past capacity.
        send_vector_pair(MAX_NONZERO + 2, MAX_NONZERO + 1, 2);
      end else if ($urandom_range(99) < 75) begin
        n_a = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
        n_b = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
        send_vector_pair(n_a, n_b, $urandom_range(1, 4));
      end else begin
        // Broken loads: stray ops, repeated and falling indexes.
        n_noise = $urandom_range(1, 16);
        repeat (n_noise) begin
          w.op = OP_W'($urandom_range(3));
          w.idx = $urandom_range(1) ? IN_INDEX_W'($urandom_range(15)) : IN_INDEX_W'($urandom);
          w.val = pick_value();
          send_word(w, 1'b0, typed_r);
        end
        w.op = OP_COMPUTE;
        w.idx = IN_INDEX_W'($urandom);
        w.val = VALUE_W'($urandom);
        send_word(w, 1'b0, typed_r);
      end
    end
    in_valid <= 1'b0;

    while (distances_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && distances_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off that
  // backs the block up while loads and computes keep coming.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 15) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (results_seen >= 60 && results_seen < 80) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each taken result with the oldest predicted distance.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (distances_due.size() == 0) begin
        $error("unexpected result word: distance_squared %0d", out_distance_squared);
        fail_cnt++;
      end else begin
        want = distances_due.pop_front();
        if (out_distance_squared !== want.sq) begin
          $error("distance_squared: expected %0d, actual %0d", want.sq, out_distance_squared);
          fail_cnt++;
        end
        if (out_distance !== want.root) begin
          $error("distance: expected %0d, actual %0d", want.root, out_distance);
          fail_cnt++;
        end
        if (out_load_error !== want.err) begin
          $error("load_error: expected %0d, actual %0d", want.err, out_load_error);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
